// ===== sv/gfg_pkg.sv =====
// Shared types, constants and codes of the gradient fill generator.
// Used by every module of the block; no dependencies.
package gfg_pkg;

	localparam int MAX_DIM_DEF = 4096;
	localparam int DIM_W       = 13;            // size register width
	localparam int OFS_W       = 12;            // offset width
	localparam int CH_W        = 8;             // color channel width
	localparam int RGB_W       = 3 * CH_W;
	localparam int WT_W        = 2 * DIM_W;     // weight and divisor width
	localparam int NUM_W       = WT_W + CH_W;   // weighted channel sum width
	localparam int NCORNER     = 4;
	localparam int NCHAN       = 3;
	localparam int IDX_W       = 3;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic [1:0] {
		FILL_FLAT  = 2'd0,
		FILL_HRAMP = 2'd1,
		FILL_VRAMP = 2'd2,
		FILL_QUAD  = 2'd3
	} fill_mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_COLOR_FIRST  = 3'd0,
		REG_COLOR_SECOND = 3'd1,
		REG_COLOR_THIRD  = 3'd2,
		REG_COLOR_FOURTH = 3'd3,
		REG_FILL_MODE    = 3'd4,
		REG_RECT_WIDTH   = 3'd5,
		REG_RECT_HEIGHT  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                           outside;
		logic [NCORNER-1:0][WT_W-1:0]   wt;
		logic [WT_W-1:0]                divisor;
	} wt_item_t;

	typedef struct packed {
		logic                           outside;
		logic [NCHAN-1:0][NUM_W-1:0]    num;
		logic [WT_W-1:0]                divisor;
	} num_item_t;

	typedef struct packed {
		logic                           outside;
		logic [NCHAN-1:0][CH_W-1:0]     chan;   // [2] red, [1] green, [0] blue
	} pix_item_t;

	// Channel k of a packed RGB word: red 23..16 is k=2, blue 7..0 is k=0.
	function automatic logic [CH_W-1:0] rgb_chan(input logic [RGB_W-1:0] rgb, input int k);
		rgb_chan = rgb[k*CH_W +: CH_W];
	endfunction

endpackage

// ===== sv/gfg_weights.sv =====
// Two-stage front end: bounds check and axis spans, then corner weights
// and the divisor for the selected fill mode. Depends on gfg_pkg.
module gfg_weights #(
	parameter int MAX_DIM = gfg_pkg::MAX_DIM_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [gfg_pkg::OFS_W-1:0]  col,
	input  logic [gfg_pkg::OFS_W-1:0]  row,
	input  gfg_pkg::fill_mode_t        mode,
	input  logic [gfg_pkg::DIM_W-1:0]  rect_w,
	input  logic [gfg_pkg::DIM_W-1:0]  rect_h,
	output logic                       out_valid,
	input  logic                       out_ready,
	output gfg_pkg::wt_item_t          out_item
);
	import gfg_pkg::*;

	logic             v_s1, v_s2, en_s1, en_s2;
	logic             outside_s1;
	logic [DIM_W-1:0] dx_s1, dy_s1, c_s1, r_s1;
	logic [DIM_W-1:0] w_c, h_c, c_x, r_x;
	wt_item_t         item_s2, item_c;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Saturate sizes to MAX_DIM.
	assign w_c = (int'(rect_w) > MAX_DIM) ? DIM_W'(MAX_DIM) : rect_w;
	assign h_c = (int'(rect_h) > MAX_DIM) ? DIM_W'(MAX_DIM) : rect_h;
	assign c_x = {1'b0, col};
	assign r_x = {1'b0, row};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			outside_s1 <= (c_x >= w_c) || (r_x >= h_c);
			dx_s1      <= (w_c > DIM_W'(1)) ? w_c - DIM_W'(1) : DIM_W'(1);
			dy_s1      <= (h_c > DIM_W'(1)) ? h_c - DIM_W'(1) : DIM_W'(1);
			c_s1       <= c_x;
			r_s1       <= r_x;
		end
	end

	always_comb begin
		logic [DIM_W-1:0] cx, ry;
		cx = dx_s1 - c_s1;
		ry = dy_s1 - r_s1;
		item_c.outside = outside_s1;
		item_c.wt      = '0;
		item_c.divisor = WT_W'(1);
		case (mode)
			FILL_HRAMP: begin
				item_c.wt[0]   = WT_W'(cx);
				item_c.wt[1]   = WT_W'(c_s1);
				item_c.divisor = WT_W'(dx_s1);
			end
			FILL_VRAMP: begin
				item_c.wt[0]   = WT_W'(ry);
				item_c.wt[1]   = WT_W'(r_s1);
				item_c.divisor = WT_W'(dy_s1);
			end
			FILL_QUAD: begin
				item_c.wt[0]   = WT_W'(cx) * WT_W'(ry);
				item_c.wt[1]   = WT_W'(c_s1) * WT_W'(ry);
				item_c.wt[2]   = WT_W'(cx) * WT_W'(r_s1);
				item_c.wt[3]   = WT_W'(c_s1) * WT_W'(r_s1);
				item_c.divisor = WT_W'(dx_s1) * WT_W'(dy_s1);
			end
			default: begin
				item_c.wt[0] = WT_W'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2 <= item_c;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

// ===== sv/gfg_mac.sv =====
// One stage of weighted sums: four corner colors times their weights,
// per channel. Depends on gfg_pkg.
module gfg_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  gfg_pkg::wt_item_t          in_item,
	input  logic [gfg_pkg::RGB_W-1:0]  color0,
	input  logic [gfg_pkg::RGB_W-1:0]  color1,
	input  logic [gfg_pkg::RGB_W-1:0]  color2,
	input  logic [gfg_pkg::RGB_W-1:0]  color3,
	output logic                       out_valid,
	input  logic                       out_ready,
	output gfg_pkg::num_item_t         out_item
);
	import gfg_pkg::*;

	logic      v_s3, en_s3;
	num_item_t item_s3, item_c;

	assign en_s3    = !v_s3 || out_ready;
	assign in_ready = en_s3;

	// Widen both factors first so the products keep their top bits.
	always_comb begin
		item_c.outside = in_item.outside;
		item_c.divisor = in_item.divisor;
		for (int k = 0; k < NCHAN; k++) begin
			item_c.num[k] = NUM_W'(in_item.wt[0]) * NUM_W'(rgb_chan(color0, k))
			              + NUM_W'(in_item.wt[1]) * NUM_W'(rgb_chan(color1, k))
			              + NUM_W'(in_item.wt[2]) * NUM_W'(rgb_chan(color2, k))
			              + NUM_W'(in_item.wt[3]) * NUM_W'(rgb_chan(color3, k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			item_s3 <= item_c;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule

// ===== sv/gfg_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for all three
// channels, eight stages. Depends on gfg_pkg.
module gfg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gfg_pkg::num_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output gfg_pkg::pix_item_t  out_item
);
	import gfg_pkg::*;

	// Quotient fits CH_W bits since, for an inside pixel, the sum never exceeds 255 times the divisor.
	logic      v_s [CH_W+1];
	logic      en_s[CH_W+1];
	num_item_t rem_s[CH_W+1];
	logic [NCHAN-1:0][CH_W-1:0] q_s[CH_W+1];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = in_item;
	assign q_s[0]   = '0;
	assign en_s[0]  = en_s[1];
	assign en_s[CH_W] = !v_s[CH_W] || out_ready;
	assign in_ready = en_s[0];

	for (genvar i = 1; i <= CH_W; i++) begin : g_step
		localparam int SH = CH_W - i;
		num_item_t                  rem_c;
		logic [NCHAN-1:0][CH_W-1:0] q_c;

		if (i < CH_W) begin : g_en
			assign en_s[i] = !v_s[i] || en_s[i+1];
		end

		always_comb begin
			logic [NUM_W-1:0] trial;
			trial = NUM_W'(rem_s[i-1].divisor) << SH;
			rem_c = rem_s[i-1];
			q_c   = q_s[i-1];
			for (int k = 0; k < NCHAN; k++) begin
				if (rem_s[i-1].num[k] >= trial) begin
					rem_c.num[k]  = rem_s[i-1].num[k] - trial;
					q_c[k][SH]    = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en_s[i]) begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_s[i]) begin
				rem_s[i] <= rem_c;
				q_s[i]   <= q_c;
			end
		end
	end

	assign out_valid        = v_s[CH_W];
	assign out_item.outside = rem_s[CH_W].outside;
	assign out_item.chan    = rem_s[CH_W].outside ? '0 : q_s[CH_W];

endmodule

// ===== sv/gradient_fill_generator.sv =====
// Top level of the gradient fill generator: configuration registers and
// the weights, multiply-accumulate and divider pipeline. Depends on gfg_pkg.
//
//   channel  direction  payload (low bit first)
//   s_*      in         tdata: col_offset[11:0], row_offset[23:12]
//   m_*      out        tdata: blue[7:0], green[15:8], red[23:16], outside[24], zero pad
//   wr_*     in         wr_index selects the register, wr_data low bits written
//
// The path from input transfer to output valid runs through two stages of spans and
// weights, one stage of products and eight divider stages (one quotient bit each).
// One pixel per cycle sustained while the output is not stalled. Reset clears the valid
// bits and the registers to their reset values. Every stage advances when it is empty
// or the next one advances, so bubbles close up under a stall.
module gradient_fill_generator #(
	parameter int MAX_DIM = gfg_pkg::MAX_DIM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [gfg_pkg::IN_TDATA_W-1:0]   s_tdata,   // col_offset, row_offset
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [gfg_pkg::OUT_TDATA_W-1:0]  m_tdata,   // blue, green, red, outside
	input  logic                             wr_en,
	input  logic [gfg_pkg::IDX_W-1:0]        wr_index,
	input  logic [gfg_pkg::RGB_W-1:0]        wr_data
);
	import gfg_pkg::*;

	logic [RGB_W-1:0] color_q[NCORNER];
	fill_mode_t       mode_q;
	logic [DIM_W-1:0] rect_w_q, rect_h_q;

	logic      wt_valid, wt_ready, num_valid, num_ready;
	wt_item_t  wt_item;
	num_item_t num_item;
	pix_item_t pix;

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCORNER; i++) color_q[i] <= '0;
			mode_q   <= FILL_FLAT;
			rect_w_q <= DIM_W'(1);
			rect_h_q <= DIM_W'(1);
		end else if (wr_en) begin
			case (wr_index)
				REG_COLOR_FIRST:  color_q[0] <= wr_data;
				REG_COLOR_SECOND: color_q[1] <= wr_data;
				REG_COLOR_THIRD:  color_q[2] <= wr_data;
				REG_COLOR_FOURTH: color_q[3] <= wr_data;
				REG_FILL_MODE:    mode_q     <= fill_mode_t'(wr_data[1:0]);
				REG_RECT_WIDTH:   rect_w_q   <= wr_data[DIM_W-1:0];
				REG_RECT_HEIGHT:  rect_h_q   <= wr_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	gfg_weights #(.MAX_DIM(MAX_DIM)) u_weights (
		.clk, .arst_n,
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.col      (s_tdata[OFS_W-1:0]),
		.row      (s_tdata[2*OFS_W-1:OFS_W]),
		.mode     (mode_q),
		.rect_w   (rect_w_q),
		.rect_h   (rect_h_q),
		.out_valid(wt_valid),
		.out_ready(wt_ready),
		.out_item (wt_item)
	);

	gfg_mac u_mac (
		.clk, .arst_n,
		.in_valid (wt_valid),
		.in_ready (wt_ready),
		.in_item  (wt_item),
		.color0   (color_q[0]),
		.color1   (color_q[1]),
		.color2   (color_q[2]),
		.color3   (color_q[3]),
		.out_valid(num_valid),
		.out_ready(num_ready),
		.out_item (num_item)
	);

	gfg_div u_div (
		.clk, .arst_n,
		.in_valid (num_valid),
		.in_ready (num_ready),
		.in_item  (num_item),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_item (pix)
	);

	assign m_tdata = {7'b0, pix.outside, pix.chan[2], pix.chan[1], pix.chan[0]};

	// Input back-pressure only when the whole pipe is full up to the output.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with room in the pipeline");

	// An outside pixel never carries color.
	a_outside_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && pix.outside |-> pix.chan == '0)
		else $error("outside pixel with nonzero color");

endmodule
